// File: sv/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg: primitive assembler shared definitions
// Mode and primitive-kind codes, register map, default widths and the
// control word that travels from the front end through the queue.
// ----------------------------------------------------------------------------
package pa_pkg;

  // default vertex tag width
  localparam int TAG_BITS_DEF = 16;

  // configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_PRIM_MODE = 3'd0;

  // primitive modes
  localparam logic [2:0] MODE_POINTS     = 3'd0;
  localparam logic [2:0] MODE_LINES      = 3'd1;
  localparam logic [2:0] MODE_LINE_STRIP = 3'd2;
  localparam logic [2:0] MODE_LINE_LOOP  = 3'd3;
  localparam logic [2:0] MODE_TRIS       = 3'd4;
  localparam logic [2:0] MODE_TRI_STRIP  = 3'd5;
  localparam logic [2:0] MODE_TRI_FAN    = 3'd6;
  localparam logic [2:0] MODE_NONE       = 3'd7;

  // primitive kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_TRI   = 2'd2;

  // queue depth between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // control part of one queued word
  typedef struct packed {
    logic [1:0] kind;   // primitive kind of the first result
    logic       close;  // a closing line follows the first result
  } pa_ctl_t;

endpackage

// File: sv/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front: vertex intake and classification
// Holds the batch tag history, decides per vertex which primitive (if any)
// it completes and pushes one queue word describing it.
// ----------------------------------------------------------------------------
module pa_front
  import pa_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          prim_mode_i,
  // vertex input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TAG_BITS-1:0] in_vertex_tag_i,
  input  logic                in_batch_last_i,
  // queue write side
  output logic                q_push_o,
  input  logic                q_ready_i,
  output pa_ctl_t             q_ctl_o,
  output logic [TAG_BITS-1:0] q_tag_a_o,
  output logic [TAG_BITS-1:0] q_tag_b_o,
  output logic [TAG_BITS-1:0] q_tag_c_o
);

  logic [TAG_BITS-1:0] anchor_r, older_r, newer_r;
  logic [1:0]          seen_r;
  logic                parity_r;
  logic [1:0]          phase_r;

  logic                emit;
  logic                close;
  logic [1:0]          kind;
  logic [TAG_BITS-1:0] ta, tb, tc;
  logic [1:0]          phase_nxt;
  logic                accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // primitive selection per mode
  always_comb begin
    emit      = 1'b0;
    close     = 1'b0;
    kind      = KIND_POINT;
    ta        = in_vertex_tag_i;
    tb        = '0;
    tc        = '0;
    phase_nxt = 2'd0;
    case (prim_mode_i)
      MODE_POINTS: begin
        emit = 1'b1;
      end
      MODE_LINES: begin
        if (phase_r[0]) begin
          emit = 1'b1;
          kind = KIND_LINE;
          ta   = newer_r;
          tb   = in_vertex_tag_i;
        end else begin
          phase_nxt = 2'd1;
        end
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (seen_r != 2'd0) begin
          emit = 1'b1;
          kind = KIND_LINE;
          ta   = newer_r;
          tb   = in_vertex_tag_i;
        end
        // closing line (v, anchor) rides along in tag_c
        if ((prim_mode_i == MODE_LINE_LOOP) && in_batch_last_i && (seen_r >= 2'd2)) begin
          close = 1'b1;
          tc    = anchor_r;
        end
      end
      MODE_TRIS: begin
        if (phase_r >= 2'd2) begin
          emit = 1'b1;
          kind = KIND_TRI;
          ta   = older_r;
          tb   = newer_r;
          tc   = in_vertex_tag_i;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      MODE_TRI_STRIP: begin
        if (seen_r >= 2'd2) begin
          emit = 1'b1;
          kind = KIND_TRI;
          ta   = parity_r ? newer_r : older_r;
          tb   = parity_r ? older_r : newer_r;
          tc   = in_vertex_tag_i;
        end
      end
      MODE_TRI_FAN: begin
        if (seen_r >= 2'd2) begin
          emit = 1'b1;
          kind = KIND_TRI;
          ta   = anchor_r;
          tb   = newer_r;
          tc   = in_vertex_tag_i;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_push_o      = accept && emit;
  assign q_ctl_o.kind  = kind;
  assign q_ctl_o.close = close;
  assign q_tag_a_o     = ta;
  assign q_tag_b_o     = tb;
  assign q_tag_c_o     = tc;

  // batch history; cleared after the last vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
      older_r  <= '0;
      newer_r  <= '0;
      seen_r   <= 2'd0;
      parity_r <= 1'b0;
      phase_r  <= 2'd0;
    end else if (accept) begin
      if (in_batch_last_i) begin
        anchor_r <= '0;
        older_r  <= '0;
        newer_r  <= '0;
        seen_r   <= 2'd0;
        parity_r <= 1'b0;
        phase_r  <= 2'd0;
      end else begin
        if (seen_r == 2'd0) begin
          anchor_r <= in_vertex_tag_i;
        end
        older_r  <= newer_r;
        newer_r  <= in_vertex_tag_i;
        if (seen_r != 2'd3) begin
          seen_r <= seen_r + 2'd1;
        end
        parity_r <= ~parity_r;
        phase_r  <= phase_nxt;
      end
    end
  end

endmodule

// File: sv/pa_queue.sv
// ----------------------------------------------------------------------------
// pa_queue: short word queue between front and back
// Flop-based FIFO; head word is read straight from the entry array.
// ----------------------------------------------------------------------------
module pa_queue
  import pa_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // write side
  input  logic                push_i,
  output logic                ready_o,
  input  pa_ctl_t             ctl_i,
  input  logic [TAG_BITS-1:0] tag_a_i,
  input  logic [TAG_BITS-1:0] tag_b_i,
  input  logic [TAG_BITS-1:0] tag_c_i,
  // read side
  output logic                valid_o,
  input  logic                pop_i,
  output pa_ctl_t             ctl_o,
  output logic [TAG_BITS-1:0] tag_a_o,
  output logic [TAG_BITS-1:0] tag_b_o,
  output logic [TAG_BITS-1:0] tag_c_o
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  pa_ctl_t             ctl_q   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_a_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_b_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_c_q [QUEUE_DEPTH];

  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_push, do_pop;

  assign ready_o = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  assign ctl_o   = ctl_q[rd_ptr_r];
  assign tag_a_o = tag_a_q[rd_ptr_r];
  assign tag_b_o = tag_b_q[rd_ptr_r];
  assign tag_c_o = tag_c_q[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wr_ptr_r]   <= ctl_i;
      tag_a_q[wr_ptr_r] <= tag_a_i;
      tag_b_q[wr_ptr_r] <= tag_b_i;
      tag_c_q[wr_ptr_r] <= tag_c_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

endmodule

// File: sv/pa_back.sv
// ----------------------------------------------------------------------------
// pa_back: primitive output stage
// Pops queue words into the output register; a word with a closing line
// produces two results, the second from a held pending line.
// ----------------------------------------------------------------------------
module pa_back
  import pa_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // queue read side
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  pa_ctl_t             q_ctl_i,
  input  logic [TAG_BITS-1:0] q_tag_a_i,
  input  logic [TAG_BITS-1:0] q_tag_b_i,
  input  logic [TAG_BITS-1:0] q_tag_c_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_prim_kind_o,
  output logic [TAG_BITS-1:0] out_tag_a_o,
  output logic [TAG_BITS-1:0] out_tag_b_o,
  output logic [TAG_BITS-1:0] out_tag_c_o,
  output logic                out_run_last_o
);

  logic                valid_r;
  logic                pend_r;
  logic [TAG_BITS-1:0] pend_a_r, pend_b_r;
  logic [1:0]          kind_r;
  logic [TAG_BITS-1:0] ta_r, tb_r, tc_r;
  logic                last_r;
  logic                load;

  assign load    = !valid_r || out_ready_i;
  assign q_pop_o = load && !pend_r && q_valid_i;

  // control: output valid and pending closing line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
      end else begin
        valid_r <= q_valid_i;
        pend_r  <= q_valid_i && q_ctl_i.close;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        kind_r <= KIND_LINE;
        ta_r   <= pend_a_r;
        tb_r   <= pend_b_r;
        tc_r   <= '0;
        last_r <= 1'b1;
      end else begin
        kind_r   <= q_ctl_i.kind;
        ta_r     <= q_tag_a_i;
        tb_r     <= q_tag_b_i;
        tc_r     <= q_ctl_i.close ? '0 : q_tag_c_i;
        last_r   <= !q_ctl_i.close;
        pend_a_r <= q_tag_b_i;
        pend_b_r <= q_tag_c_i;
      end
    end
  end

  assign out_valid_o     = valid_r;
  assign out_prim_kind_o = kind_r;
  assign out_tag_a_o     = ta_r;
  assign out_tag_b_o     = tb_r;
  assign out_tag_c_o     = tc_r;
  assign out_run_last_o  = last_r;

endmodule

// File: sv/primitive_assembler.sv
// ----------------------------------------------------------------------------
// primitive_assembler: streaming primitive assembly
// Turns a stream of vertex tags into point, line and triangle primitives
// following the configured primitive mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | word
//  --------+-----------+------------------+-----------------------------------
//  in_     | input     | valid / ready    | vertex_tag, batch_last
//  out_    | output    | valid / ready    | prim_kind, tag_a, tag_b, tag_c,
//          |           |                  | run_last
//  cfg     | input     | APB (psel/...)   | prim_mode at address 0
//
//  One vertex is taken every cycle while the queue has room; its primitive is
//  decoded by the front, written into the queue at the accepting edge and
//  then loaded from the queue head into the output register.
//  A line loop's final vertex yields two results and holds the output stage
//  until the second is loaded; the two-entry queue absorbs that and output stalls.
//  rst_n is synchronous; it clears prim_mode, the batch history and queue.
//  Input ready drops only while the queue is full.
// ----------------------------------------------------------------------------
module primitive_assembler
  import pa_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // vertex input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TAG_BITS-1:0]      in_vertex_tag,
  input  logic                     in_batch_last,
  // primitive output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_prim_kind,
  output logic [TAG_BITS-1:0]      out_tag_a,
  output logic [TAG_BITS-1:0]      out_tag_b,
  output logic [TAG_BITS-1:0]      out_tag_c,
  output logic                     out_run_last
);

  logic [2:0]          prim_mode_r;
  logic                q_push, q_wready, q_valid, q_pop;
  pa_ctl_t             w_ctl, r_ctl;
  logic [TAG_BITS-1:0] w_a, w_b, w_c, r_a, r_b, r_c;

  // mode register write and readback
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_mode_r <= MODE_POINTS;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_PRIM_MODE)) begin
      prim_mode_r <= pwdata[2:0];
    end
  end
  assign prdata = (paddr == ADDR_PRIM_MODE) ? {{(APB_DATA_BITS-3){1'b0}}, prim_mode_r} : '0;

  pa_front #(.TAG_BITS(TAG_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .prim_mode_i     (prim_mode_r),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .in_vertex_tag_i (in_vertex_tag),
    .in_batch_last_i (in_batch_last),
    .q_push_o        (q_push),
    .q_ready_i       (q_wready),
    .q_ctl_o         (w_ctl),
    .q_tag_a_o       (w_a),
    .q_tag_b_o       (w_b),
    .q_tag_c_o       (w_c)
  );

  pa_queue #(.TAG_BITS(TAG_BITS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .ready_o (q_wready),
    .ctl_i   (w_ctl),
    .tag_a_i (w_a),
    .tag_b_i (w_b),
    .tag_c_i (w_c),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .ctl_o   (r_ctl),
    .tag_a_o (r_a),
    .tag_b_o (r_b),
    .tag_c_o (r_c)
  );

  pa_back #(.TAG_BITS(TAG_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_ctl_i         (r_ctl),
    .q_tag_a_i       (r_a),
    .q_tag_b_i       (r_b),
    .q_tag_c_i       (r_c),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_prim_kind_o (out_prim_kind),
    .out_tag_a_o     (out_tag_a),
    .out_tag_b_o     (out_tag_b),
    .out_tag_c_o     (out_tag_c),
    .out_run_last_o  (out_run_last)
  );

endmodule

// File: sv/pa_checker.sv
// ----------------------------------------------------------------------------
// pa_checker: port-level checks for the primitive assembler
// Watches the output word over time and the shape of each primitive.
// ----------------------------------------------------------------------------
module pa_checker
  import pa_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_prim_kind,
  input logic [TAG_BITS-1:0] out_tag_b,
  input logic [TAG_BITS-1:0] out_tag_c,
  input logic                out_run_last
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prim_kind) && $stable(out_run_last))
    else $error("output word dropped or changed while stalled");

  // only point, line and triangle kinds leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prim_kind == KIND_POINT || out_prim_kind == KIND_LINE ||
                   out_prim_kind == KIND_TRI))
    else $error("illegal primitive kind");

  // points carry only tag_a
  a_point_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_prim_kind == KIND_POINT) |-> (out_tag_b == '0) && (out_tag_c == '0))
    else $error("point with nonzero tag_b or tag_c");

  // lines carry no third tag
  a_line_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_prim_kind == KIND_LINE) |-> (out_tag_c == '0))
    else $error("line with nonzero tag_c");

  // a result not marked last is followed by the closing line of a loop
  a_run_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=>
      out_valid && out_run_last && (out_prim_kind == KIND_LINE))
    else $error("first of a result pair not followed by closing line");

endmodule

bind primitive_assembler pa_checker #(.TAG_BITS(TAG_BITS)) u_pa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_prim_kind (out_prim_kind),
  .out_tag_b     (out_tag_b),
  .out_tag_c     (out_tag_c),
  .out_run_last  (out_run_last)
);

// File: tb/primitive_assembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_assembler_tb: self-checking bench for the primitive assembler
// Vertex words go in through a queue-fed driver with random gaps. Expected
// primitives are built by a local assembly model at input acceptance and
// compared field by field with each output word. The mode is changed only
// while the block is idle, sometimes in the middle of a batch.
// ----------------------------------------------------------------------------
module primitive_assembler_tb;
  import pa_pkg::*;

  localparam int TAGW         = TAG_BITS_DEF;
  localparam int SETTLE_TICKS = 8;       // pipeline latency plus margin
  localparam int CYCLE_LIMIT  = 600000;
  localparam int ITEM_TARGET  = 950;

  typedef struct packed {
    logic [TAGW-1:0] tag;
    logic            last;
  } vertex_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [TAGW-1:0] a;
    logic [TAGW-1:0] b;
    logic [TAGW-1:0] c;
    logic            run_last;
  } prim_t;

  // DUT connections
  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [TAGW-1:0]          in_vertex_tag = '0;
  logic                     in_batch_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_prim_kind;
  logic [TAGW-1:0]          out_tag_a;
  logic [TAGW-1:0]          out_tag_b;
  logic [TAGW-1:0]          out_tag_c;
  logic                     out_run_last;

  primitive_assembler u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vertex_tag (in_vertex_tag),
    .in_batch_last (in_batch_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prim_kind (out_prim_kind),
    .out_tag_a     (out_tag_a),
    .out_tag_b     (out_tag_b),
    .out_tag_c     (out_tag_c),
    .out_run_last  (out_run_last)
  );

  // bench state
  vertex_t     vertices_pending[$];
  prim_t       prims_due[$];
  vertex_t     next_vertex;
  prim_t       got_prim;
  prim_t       want_prim;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          items_queued = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;
  int unsigned batch_left = 0;

  // local assembly state, mirrors the block after reset
  logic [2:0]      cfg_mode = MODE_POINTS;
  logic [TAGW-1:0] asm_anchor = '0;
  logic [TAGW-1:0] asm_older = '0;
  logic [TAGW-1:0] asm_newer = '0;
  logic [1:0]      asm_seen = '0;
  logic            asm_parity = 1'b0;
  logic [1:0]      asm_phase = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle span: mostly none or short, a few long, plus calm stretches
  function automatic int unsigned idle_span(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic prim_t make_prim(input logic [1:0] kind, input logic [TAGW-1:0] a,
                                      input logic [TAGW-1:0] b, input logic [TAGW-1:0] c);
    prim_t p;
    p.kind     = kind;
    p.a        = a;
    p.b        = b;
    p.c        = c;
    p.run_last = 1'b0;
    return p;
  endfunction

  // build the primitives one vertex causes and advance the tag history
  task automatic assemble_vertex(input vertex_t vx);
    prim_t      made[$];
    logic [1:0] phase_next;
    phase_next = '0;
    case (cfg_mode)
      MODE_POINTS: made.push_back(make_prim(KIND_POINT, vx.tag, '0, '0));
      MODE_LINES: begin
        if (asm_phase[0]) made.push_back(make_prim(KIND_LINE, asm_newer, vx.tag, '0));
        else phase_next = 2'd1;
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (asm_seen >= 2'd1) made.push_back(make_prim(KIND_LINE, asm_newer, vx.tag, '0));
        // closing line only once at least two vertices came before
        if (cfg_mode == MODE_LINE_LOOP && vx.last && asm_seen >= 2'd2)
          made.push_back(make_prim(KIND_LINE, vx.tag, asm_anchor, '0));
      end
      MODE_TRIS: begin
        if (asm_phase >= 2'd2) made.push_back(make_prim(KIND_TRI, asm_older, asm_newer, vx.tag));
        else phase_next = asm_phase + 2'd1;
      end
      MODE_TRI_STRIP: begin
        // odd positions swap the first two tags to keep winding
        if (asm_seen >= 2'd2) begin
          if (asm_parity) made.push_back(make_prim(KIND_TRI, asm_newer, asm_older, vx.tag));
          else made.push_back(make_prim(KIND_TRI, asm_older, asm_newer, vx.tag));
        end
      end
      MODE_TRI_FAN: begin
        if (asm_seen >= 2'd2) made.push_back(make_prim(KIND_TRI, asm_anchor, asm_newer, vx.tag));
      end
      default: ;
    endcase
    if (made.size() != 0) made[made.size()-1].run_last = 1'b1;
    foreach (made[i]) prims_due.push_back(made[i]);

    if (vx.last) begin
      asm_anchor = '0;
      asm_older  = '0;
      asm_newer  = '0;
      asm_seen   = '0;
      asm_parity = 1'b0;
      asm_phase  = '0;
    end else begin
      if (asm_seen == 2'd0) asm_anchor = vx.tag;
      asm_older  = asm_newer;
      asm_newer  = vx.tag;
      if (asm_seen != 2'd3) asm_seen = asm_seen + 2'd1;
      asm_parity = ~asm_parity;
      asm_phase  = phase_next;
    end
  endtask

  function automatic void check_field(input string name, input logic [TAGW-1:0] want,
                                      input logic [TAGW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // vertex driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) assemble_vertex(vertex_t'{in_vertex_tag, in_batch_last});
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (vertices_pending.size() != 0) begin
        next_vertex = vertices_pending.pop_front();
        in_vertex_tag <= next_vertex.tag;
        in_batch_last <= next_vertex.last;
        in_valid      <= 1'b1;
        tx_gap = idle_span(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // primitive monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_prim = prim_t'{out_prim_kind, out_tag_a, out_tag_b, out_tag_c, out_run_last};
        if (prims_due.size() == 0) begin
          $error("unexpected primitive word: kind %0d tags %h %h %h", got_prim.kind,
                 got_prim.a, got_prim.b, got_prim.c);
          fail_count++;
        end else begin
          want_prim = prims_due.pop_front();
          check_field("prim_kind", TAGW'(want_prim.kind), TAGW'(got_prim.kind));
          check_field("tag_a", want_prim.a, got_prim.a);
          check_field("tag_b", want_prim.b, got_prim.b);
          check_field("tag_c", want_prim.c, got_prim.c);
          check_field("run_last", TAGW'(want_prim.run_last), TAGW'(got_prim.run_last));
        end
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
        rx_stall = idle_span(rx_calm);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("primitive_assembler: mismatch");
      $finish;
    end
  end

  task automatic queue_vertex(input logic [TAGW-1:0] tag, input logic last);
    vertices_pending.push_back(vertex_t'{tag, last});
    items_queued++;
  endtask

  // wait until every word is taken and every primitive has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (vertices_pending.size() != 0 || in_valid || prims_due.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic program_mode(input logic [2:0] mode);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PRIM_MODE;
    pwdata  <= APB_DATA_BITS'(mode);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_mode = mode;
  endtask

  function automatic logic [TAGW-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return TAGW'(1) << $urandom_range(0, TAGW - 1);
    return TAGW'($urandom_range(0, (1 << TAGW) - 1));
  endfunction

  // random well-formed batches; a batch may run across a mode change
  task automatic queue_random(input int count);
    int unsigned r;
    repeat (count) begin
      if (batch_left == 0) begin
        r = $urandom_range(0, 9);
        if (r < 5) batch_left = $urandom_range(1, 4);
        else if (r < 9) batch_left = $urandom_range(5, 12);
        else batch_left = $urandom_range(13, 40);
      end
      queue_vertex(pick_tag(), batch_left == 1);
      batch_left--;
    end
  endtask

  // stimulus
  initial begin
    int phase_no;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-vertex point batch at the top tag
    program_mode(MODE_POINTS);
    queue_vertex('1, 1'b1);
    // two-vertex loop has no closing line; three-vertex loop does
    program_mode(MODE_LINE_LOOP);
    queue_vertex('0, 1'b0);
    queue_vertex('1, 1'b1);
    queue_vertex(16'h0001, 1'b0);
    queue_vertex(16'h0002, 1'b0);
    queue_vertex(16'h0003, 1'b1);
    // odd trailing vertex of a line list is dropped
    program_mode(MODE_LINES);
    queue_vertex(16'hAAAA, 1'b0);
    queue_vertex(16'h5555, 1'b0);
    queue_vertex(16'h8001, 1'b1);
    program_mode(MODE_LINE_STRIP);
    queue_vertex(16'h1234, 1'b0);
    queue_vertex(16'hFEDC, 1'b0);
    queue_vertex(16'h7FFF, 1'b1);
    // partial second triangle is dropped
    program_mode(MODE_TRIS);
    queue_vertex(16'h0100, 1'b0);
    queue_vertex(16'h0200, 1'b0);
    queue_vertex(16'h0300, 1'b0);
    queue_vertex(16'h0400, 1'b1);
    program_mode(MODE_TRI_STRIP);
    queue_vertex(16'h0011, 1'b0);
    queue_vertex(16'h0022, 1'b0);
    queue_vertex(16'h0033, 1'b0);
    queue_vertex(16'h0044, 1'b1);
    // no output in mode none, then switch to fan inside the same batch
    program_mode(MODE_NONE);
    queue_vertex(16'h0010, 1'b0);
    queue_vertex(16'h0020, 1'b0);
    program_mode(MODE_TRI_FAN);
    queue_vertex(16'h0030, 1'b0);
    queue_vertex(16'h0040, 1'b1);

    // random phases: every mode first, then random; some keep the mode
    phase_no = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase_no < 8) program_mode(3'(phase_no));
      else if ($urandom_range(0, 3) != 0) program_mode(3'($urandom_range(0, 7)));
      else wait_idle();
      queue_random($urandom_range(30, 90));
      phase_no++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("primitive_assembler: match");
    end else begin
      $display("primitive_assembler: mismatch");
    end
    $finish;
  end

endmodule
